### design/sss_pkg.sv
// Shared types and constants for the staggered spin-up scheduler.
// No dependencies; imported by the top level and the port checker.
package sss_pkg;

	localparam int TOKENS_MAX  = 8;
	localparam int SECONDS_MAX = 6;
	localparam int TPS_MAX     = 1000;
	localparam int MAX_RESULTS = 16;

	// input modes
	localparam logic [1:0] MODE_CMD  = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_SET  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TOKENS = 2'd0;
	localparam logic [1:0] CFG_SECS   = 2'd1;
	localparam logic [1:0] CFG_TPS    = 2'd2;

	// event codes
	localparam logic [2:0] EV_PASS = 3'd0;
	localparam logic [2:0] EV_HELD = 3'd1;
	localparam logic [2:0] EV_WEND = 3'd2;
	localparam logic [2:0] EV_SBY  = 3'd3;
	localparam logic [2:0] EV_SET  = 3'd4;

	// power states
	localparam logic [2:0] PS_ACTIVE  = 3'd0;
	localparam logic [2:0] PS_STANDBY = 3'd1;
	localparam logic [2:0] PS_SBWAIT  = 3'd2;
	localparam logic [2:0] PS_PASSED  = 3'd3;
	localparam logic [2:0] PS_WAITING = 3'd4;
	localparam logic [2:0] PS_SPIN    = 3'd5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  disk;
		logic [2:0]  new_power_state;
		logic [24:0] standby_ticks;
	} item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [3:0] disk_res;
		logic       released_valid;
		logic [3:0] released_disk;
		logic [2:0] power_state;
		logic [3:0] tokens_free;
		logic       last;
	} result_t;

	// one disk's entry in the state memory
	typedef struct packed {
		logic [2:0]  ps;
		logic [12:0] spin;
		logic [24:0] sby;
		logic [24:0] per;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD,
		ST_SET,
		ST_TRD,
		ST_TEXE,
		ST_RRD,
		ST_RWR,
		ST_TSBY,
		ST_FLUSH
	} state_t;

endpackage

### design/staggered_spinup_scheduler_top.sv
// Staggered spin-up scheduler: token pool, wait queue and per-disk timers.
// Depends on sss_pkg (types, codes, limits).
//
// A command or state-set item for a disk in range gives a single result,
// strobed in the first cycle in which busy is low again; an item for a disk
// out of range gives none. A tick walks the state memory one disk per cycle
// except where it stops: a queued disk released into an entry other than
// the one being stepped is read and rewritten before the walk reads on,
// and a disk whose window ends and standby expires on the same tick takes
// a further step to report the expiry. These extra steps arise because the
// state memory has one read and one write port. Results are held one deep
// so the final one can be flagged last; each comes with a one-cycle strobe
// and must be taken that cycle. No clearing pass is needed: per-entry
// valid bits stand for the reset value.
module staggered_spinup_scheduler_top #(
	parameter int DISKS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sss_pkg::item_t  item,
	output logic            result_strobe,
	output sss_pkg::result_t result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [9:0]      cfg_data
);
	import sss_pkg::*;

	localparam int DW = (DISKS > 1) ? $clog2(DISKS) : 1;
	localparam int CW = $clog2(DISKS + 1);
	localparam int SW = CW + 1;

	// configuration
	logic [3:0]  tok_max_q;
	logic [2:0]  secs_q;
	logic [9:0]  tps_q;
	logic [12:0] win_q;
	logic [12:0] prod;

	// control
	state_t          st_q, st_n;
	item_t           item_q;
	logic [DW-1:0]   idx_q, idx_n;
	logic [DW-1:0]   who_q, who_n;
	logic            exp_q, exp_n;
	logic [4:0]      cnt_q;
	logic [3:0]      tok_q, tok_n;
	logic [DISKS-1:0] fresh_q;
	logic [DW-1:0]   qhead_q, qhead_n;
	logic [CW-1:0]   qcnt_q, qcnt_n;
	logic            pend_v_q;
	result_t         pend_q;
	result_t         res_q;
	logic            strobe_q;

	// memories
	entry_t          dmem [DISKS];
	logic [DISKS-1:0] vld_q;
	logic [3:0]      qmem [DISKS];
	entry_t          rdata_s1;
	logic            rvld_s1;
	logic [3:0]      qdata_s1;

	// datapath decode
	logic            accept;
	logic            feat;
	logic            disk_ok;
	logic            last_disk;
	logic [DW-1:0]   rd_addr;
	logic            we;
	logic [DW-1:0]   wa;
	entry_t          wd;
	entry_t          e;
	logic            qwe;
	logic [DW-1:0]   qtail;
	logic [SW-1:0]   tsum;
	logic            gen_v;
	result_t         gen;
	logic            rel_go;
	logic            fresh_set;
	logic            win_end;
	logic            exp_now;
	logic [DW-1:0]   qdisk;
	logic [3:0]      tok_inc;
	logic [2:0]      set_ps;

	assign accept    = start && !busy;
	assign busy      = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign feat      = (tok_max_q != 4'd0) && (secs_q != 3'd0);
	assign disk_ok   = (32'(item_q.disk) < DISKS);
	assign last_disk = (idx_q == DW'(DISKS - 1));
	assign e         = rvld_s1 ? rdata_s1 : '0;
	assign qdisk     = DW'(qdata_s1);
	assign tsum      = SW'(qhead_q) + SW'(qcnt_q);
	assign qtail     = (tsum >= SW'(DISKS)) ? DW'(tsum - SW'(DISKS)) : DW'(tsum);
	assign tok_inc   = (tok_q == 4'(TOKENS_MAX)) ? tok_q : tok_q + 4'd1;
	assign set_ps    = (item_q.new_power_state > PS_SPIN) ? PS_SPIN : item_q.new_power_state;
	assign prod      = 13'(secs_q) * 13'(tps_q);

	// configuration writes; window length is a registered product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_max_q <= '0;
			secs_q    <= '0;
			tps_q     <= 10'(TPS_MAX);
			win_q     <= 13'd1;
		end else begin
			win_q <= (prod[12:0] == 13'd0) ? 13'd1 : prod[12:0];
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TOKENS: tok_max_q <= (cfg_data[3:0] > 4'(TOKENS_MAX)) ?
						4'(TOKENS_MAX) : cfg_data[3:0];
					CFG_SECS:   secs_q <= (cfg_data[2:0] == 3'd7) ?
						3'(SECONDS_MAX) : cfg_data[2:0];
					CFG_TPS:    tps_q <= (cfg_data == 10'd0) ? 10'd1 :
						((cfg_data > 10'(TPS_MAX)) ? 10'(TPS_MAX) : cfg_data);
					default: ;
				endcase
			end
		end
	end

	// datapath: memory addresses, write data, token and queue updates
	always_comb begin
		rd_addr   = idx_q;
		we        = 1'b0;
		wa        = idx_q;
		wd        = e;
		qwe       = 1'b0;
		gen_v     = 1'b0;
		gen       = '0;
		tok_n     = tok_q;
		qhead_n   = qhead_q;
		qcnt_n    = qcnt_q;
		who_n     = who_q;
		exp_n     = exp_q;
		rel_go    = 1'b0;
		fresh_set = 1'b0;
		win_end   = 1'b0;
		exp_now   = 1'b0;
		idx_n     = idx_q;
		unique case (st_q)
			ST_IDLE: begin
				rd_addr = (item.mode == MODE_TICK) ? '0 : DW'(item.disk);
				idx_n   = '0;
				exp_n   = 1'b0;
			end
			ST_CMD: begin
				wa             = DW'(item_q.disk);
				gen_v          = 1'b1;
				gen.event_res  = EV_PASS;
				gen.disk_res   = item_q.disk;
				if (feat) begin
					if (e.ps == PS_STANDBY || e.ps == PS_PASSED) begin
						we = 1'b1;
						if (tok_q != 4'd0) begin
							tok_n   = tok_q - 4'd1;
							wd.ps   = PS_SPIN;
							wd.spin = win_q;
						end else begin
							wd.ps         = PS_WAITING;
							gen.event_res = EV_HELD;
							if (32'(qcnt_q) < DISKS) begin
								qwe    = 1'b1;
								qcnt_n = qcnt_q + CW'(1);
							end
						end
					end else if (e.ps == PS_SBWAIT) begin
						we     = 1'b1;
						wd.sby = (e.per == 25'd0) ? 25'd1 : e.per;
					end
				end
				gen.power_state = wd.ps;
				gen.tokens_free = tok_n;
			end
			ST_SET: begin
				we              = 1'b1;
				wa              = DW'(item_q.disk);
				wd.ps           = set_ps;
				wd.per          = item_q.standby_ticks;
				gen_v           = 1'b1;
				gen.event_res   = EV_SET;
				gen.disk_res    = item_q.disk;
				gen.power_state = set_ps;
				gen.tokens_free = tok_q;
			end
			ST_TRD: begin
				rd_addr = idx_q;
			end
			ST_TEXE: begin
				we = 1'b1;
				// spin-up window countdown
				if (e.spin != 13'd0 && !fresh_q[idx_q]) begin
					wd.spin = e.spin - 13'd1;
					win_end = (e.spin == 13'd1);
				end
				if (win_end) begin
					tok_n = tok_inc;
					if (qcnt_q != CW'(0)) begin
						rel_go    = 1'b1;
						fresh_set = 1'b1;
						tok_n     = tok_inc - 4'd1;
						who_n     = qdisk;
						qhead_n   = (qhead_q == DW'(DISKS - 1)) ? '0 : qhead_q + DW'(1);
						qcnt_n    = qcnt_q - CW'(1);
						if (qdisk == idx_q) begin
							wd.ps   = PS_SPIN;
							wd.spin = win_q;
						end
					end
					gen_v              = 1'b1;
					gen.event_res      = EV_WEND;
					gen.disk_res       = 4'(idx_q);
					gen.released_valid = rel_go;
					gen.released_disk  = rel_go ? qdata_s1 : 4'd0;
					gen.power_state    = wd.ps;
					gen.tokens_free    = tok_n;
				end
				// standby countdown
				if (e.sby != 25'd0) begin
					wd.sby  = e.sby - 25'd1;
					exp_now = (e.sby == 25'd1);
				end
				if (exp_now) begin
					wd.ps = PS_PASSED;
				end
				exp_n = exp_now && win_end;
				if (exp_now && !win_end) begin
					gen_v           = 1'b1;
					gen.event_res   = EV_SBY;
					gen.disk_res    = 4'(idx_q);
					gen.power_state = PS_PASSED;
					gen.tokens_free = tok_q;
				end
				if (!(rel_go && qdisk != idx_q) && !exp_n && !last_disk) begin
					idx_n   = idx_q + DW'(1);
					rd_addr = idx_q + DW'(1);
				end
				if (rel_go && qdisk != idx_q) begin
					rd_addr = qdisk;
				end
			end
			ST_RRD: begin
				rd_addr = who_q;
			end
			ST_RWR: begin
				we      = 1'b1;
				wa      = who_q;
				wd.ps   = PS_SPIN;
				wd.spin = win_q;
				if (!exp_q && !last_disk) begin
					idx_n = idx_q + DW'(1);
				end
			end
			ST_TSBY: begin
				gen_v           = 1'b1;
				gen.event_res   = EV_SBY;
				gen.disk_res    = 4'(idx_q);
				gen.power_state = PS_PASSED;
				gen.tokens_free = tok_q;
				exp_n           = 1'b0;
				if (!last_disk) begin
					idx_n = idx_q + DW'(1);
				end
			end
			ST_FLUSH: ;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.mode == MODE_TICK) begin
						st_n = ST_TEXE;
					end else if (item.mode == MODE_CMD && 32'(item.disk) < DISKS) begin
						st_n = ST_CMD;
					end else if (item.mode == MODE_SET && 32'(item.disk) < DISKS) begin
						st_n = ST_SET;
					end else begin
						st_n = ST_FLUSH;
					end
				end
			end
			ST_CMD:  st_n = disk_ok ? ST_FLUSH : ST_FLUSH;
			ST_SET:  st_n = ST_FLUSH;
			ST_TRD:  st_n = ST_TEXE;
			ST_TEXE: begin
				priority if (rel_go && qdisk != idx_q) st_n = ST_RRD;
				else if (exp_n)                       st_n = ST_TSBY;
				else if (last_disk)                   st_n = ST_FLUSH;
				else                                  st_n = ST_TEXE;
			end
			ST_RRD:  st_n = ST_RWR;
			ST_RWR: begin
				priority if (exp_q) st_n = ST_TSBY;
				else if (last_disk) st_n = ST_FLUSH;
				else                st_n = ST_TRD;
			end
			ST_TSBY: st_n = last_disk ? ST_FLUSH : ST_TRD;
			ST_FLUSH: st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			idx_q    <= '0;
			who_q    <= '0;
			exp_q    <= 1'b0;
			cnt_q    <= '0;
			tok_q    <= '0;
			fresh_q  <= '0;
			qhead_q  <= '0;
			qcnt_q   <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
			vld_q    <= '0;
		end else begin
			st_q     <= st_n;
			idx_q    <= idx_n;
			who_q    <= who_n;
			exp_q    <= exp_n;
			tok_q    <= tok_n;
			qhead_q  <= qhead_n;
			qcnt_q   <= qcnt_n;
			strobe_q <= 1'b0;
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (accept) begin
				cnt_q   <= '0;
				fresh_q <= '0;
			end
			if (fresh_set) begin
				fresh_q[qdisk] <= 1'b1;
			end
			// hold one result back so the final one can carry last
			if (gen_v && cnt_q < 5'(MAX_RESULTS)) begin
				cnt_q    <= cnt_q + 5'd1;
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					strobe_q <= 1'b1;
				end
			end
			if (st_q == ST_FLUSH && pend_v_q) begin
				strobe_q <= 1'b1;
				pend_v_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_TOKENS) begin
				tok_q <= (cfg_data[3:0] > 4'(TOKENS_MAX)) ? 4'(TOKENS_MAX) : cfg_data[3:0];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (gen_v && cnt_q < 5'(MAX_RESULTS)) begin
			pend_q <= gen;
			if (pend_v_q) begin
				res_q      <= pend_q;
				res_q.last <= 1'b0;
			end
		end
		if (st_q == ST_FLUSH && pend_v_q) begin
			res_q      <= pend_q;
			res_q.last <= 1'b1;
		end
	end

	// per-disk state memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			dmem[wa] <= wd;
		end
		rdata_s1 <= dmem[rd_addr];
		rvld_s1  <= vld_q[rd_addr];
	end

	// wait queue memory; the next head entry is read every cycle so the
	// head data is current right after a release
	always_ff @(posedge clk) begin
		if (qwe) begin
			qmem[qtail] <= item_q.disk;
		end
		qdata_s1 <= qmem[qhead_n];
	end

	assign result_strobe = strobe_q;
	assign result        = res_q;

endmodule

### design/sss_port_checker.sv
// Port-level checks for the staggered spin-up scheduler, bound to the top.
// Depends on sss_pkg for result codes and limits.
module sss_port_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             result_strobe,
	input sss_pkg::result_t result
);
	import sss_pkg::*;

	// an accepted transaction always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted transaction");

	// the final result of a transaction is not followed at once by another
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |=> !result_strobe)
		else $error("result right after a last result");

	// a release is reported only with a window end
	a_release_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.released_valid |-> result.event_res == EV_WEND)
		else $error("release outside a window end");

	// reported token count never exceeds TOKENS_MAX
	a_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> result.tokens_free <= 4'(TOKENS_MAX))
		else $error("tokens_free above limit");

endmodule

bind staggered_spinup_scheduler_top sss_port_checker u_sss_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.result        (result)
);
